FILE: sv/hql_pkg.sv
// Shared types and constants for the hierarchical quota ledger.
// No dependencies; imported by hql_alu, the top level and the testbench.
package hql_pkg;

    localparam int HQL_NUM_ACCOUNTS = 64;
    localparam int HQL_MAX_DEPTH    = 16;

    localparam int ID_W     = 6;
    localparam int AMOUNT_W = 32;
    localparam int VALUE_W  = 64;

    typedef enum logic [2:0] {
        REQ_CREATE    = 3'd0,
        REQ_RESERVE   = 3'd1,
        REQ_UNRESERVE = 3'd2,
        REQ_SET_LIMIT = 3'd3,
        REQ_READ      = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LIMIT     = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DEEP      = 3'd3,
        ST_INVALID   = 3'd4
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    // One account as stored in the table RAM.
    typedef struct packed {
        logic               valid;
        logic               has_parent;
        logic [ID_W-1:0]    parent;
        logic [VALUE_W-1:0] limit;
        logic [VALUE_W-1:0] used;
    } t_entry;

endpackage

FILE: sv/hql_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/hql_alu.sv
// Shared 64-bit add/subtract unit used for every per-account check and update.
// Depends on hql_pkg.
module hql_alu
    import hql_pkg::*;
(
    input  t_alu_op            i_op,
    input  logic [VALUE_W-1:0] i_a,
    input  logic [VALUE_W-1:0] i_b,
    output logic [VALUE_W-1:0] o_res,
    output logic               o_flag   // carry out on add, borrow on subtract
);

    logic [VALUE_W:0] sum;

    always_comb begin
        unique case (i_op)
            ALU_ADD: sum = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: sum = {1'b0, i_a} + {1'b0, ~i_b} + {{VALUE_W{1'b0}}, 1'b1};
            default: sum = '0;
        endcase
    end

    assign o_res  = sum[VALUE_W-1:0];
    assign o_flag = (i_op == ALU_ADD) ? sum[VALUE_W] : ~sum[VALUE_W];

endmodule

FILE: sv/hierarchical_quota_ledger.sv
// Top level of the hierarchical quota ledger: sequencer, account table, shared ALU.
// Depends on hql_pkg, hql_ram, hql_alu.
//
// Requests are taken when start is high and busy is low; each gives exactly one
// result word on the o_ ports, marked by o_done for one cycle, which the receiver
// must take. After reset the table is swept clear, one account a cycle, while busy
// stays high. The table is one RAM with a registered read and the walk reads one
// account per cycle along the chain (account plus ancestors): reserve and unreserve
// make a check pass, then a commit pass; a refused one makes the check pass only.
// Read limits walks the chain once, set limit touches only the account, and create
// of a child walks the parent's chain. The default depth bound is 16.
module hierarchical_quota_ledger
    import hql_pkg::*;
#(
    parameter int NUM_ACCOUNTS = HQL_NUM_ACCOUNTS,
    parameter int MAX_DEPTH    = HQL_MAX_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_req_type,
    input  logic [ID_W-1:0]     i_account_id,
    input  logic [ID_W-1:0]     i_parent_id,
    input  logic                i_has_parent,
    input  logic [AMOUNT_W-1:0] i_amount,
    input  logic [VALUE_W-1:0]  i_limit_value,
    output logic                o_done,
    output logic [2:0]          o_status,
    output logic [VALUE_W-1:0]  o_own_limit,
    output logic [VALUE_W-1:0]  o_own_used,
    output logic [VALUE_W-1:0]  o_effective_limit,
    output logic [VALUE_W-1:0]  o_effective_headroom
);

    localparam int AW      = $clog2(NUM_ACCOUNTS);
    localparam int XW      = AW + ID_W;
    localparam int CW      = $clog2(MAX_DEPTH + 1);
    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CREATE,
        S_WALK,
        S_COMMIT
    } t_state;

    function automatic logic in_range(input logic [ID_W-1:0] id);
        logic [XW-1:0] ext;
        ext = XW'(id);
        return ext < XW'(NUM_ACCOUNTS);
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [ID_W-1:0] id);
        logic [XW-1:0] ext;
        ext = XW'(id);
        return ext[AW-1:0];
    endfunction

    // Registers
    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [2:0]          r_req, n_req;
    logic [ID_W-1:0]     r_id, n_id;
    logic [ID_W-1:0]     r_pid, n_pid;
    logic                r_hp, n_hp;
    logic [AMOUNT_W-1:0] r_amt, n_amt;
    logic [VALUE_W-1:0]  r_lim, n_lim;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_first, n_first;
    logic                r_fail, n_fail;
    logic [VALUE_W-1:0]  r_eff, n_eff;
    logic [VALUE_W-1:0]  r_room, n_room;
    logic [VALUE_W-1:0]  r_own_lim, n_own_lim;
    logic [VALUE_W-1:0]  r_own_used, n_own_used;
    logic                r_done, n_done;
    logic [2:0]          r_status, n_status;
    logic [VALUE_W-1:0]  r_o_lim, n_o_lim;
    logic [VALUE_W-1:0]  r_o_used, n_o_used;
    logic [VALUE_W-1:0]  r_o_eff, n_o_eff;
    logic [VALUE_W-1:0]  r_o_room, n_o_room;

    // Table RAM
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_entry             ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             d;

    hql_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_ACCOUNTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign d = t_entry'(ram_rdata);

    // Shared ALU
    t_alu_op            alu_op;
    logic [VALUE_W-1:0] alu_a, alu_b, alu_res;
    logic               alu_flag;

    hql_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res),
        .o_flag(alu_flag)
    );

    always_comb begin
        priority case (r_req)
            REQ_RESERVE: begin
                alu_op = ALU_ADD;
                alu_a  = d.used;
                alu_b  = VALUE_W'(r_amt);
            end
            REQ_UNRESERVE: begin
                alu_op = ALU_SUB;
                alu_a  = d.used;
                alu_b  = VALUE_W'(r_amt);
            end
            default: begin
                // headroom: limit - used
                alu_op = ALU_SUB;
                alu_a  = d.limit;
                alu_b  = d.used;
            end
        endcase
    end

    // Per-node results
    logic               node_fail;
    logic [VALUE_W-1:0] node_room;
    logic [CW-1:0]      cnt1;

    always_comb begin
        if (r_req == REQ_RESERVE) begin
            node_fail = alu_flag | (alu_res > d.limit);
        end else begin
            node_fail = alu_flag;
        end
        node_room = alu_flag ? '0 : alu_res;
        cnt1      = r_cnt + CW'(1);
    end

    // Sequencer
    logic          fin;
    t_status       fin_st;
    logic          walk_stop;
    logic [CW-1:0] end_n;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_req      = r_req;
        n_id       = r_id;
        n_pid      = r_pid;
        n_hp       = r_hp;
        n_amt      = r_amt;
        n_lim      = r_lim;
        n_cnt      = r_cnt;
        n_first    = r_first;
        n_fail     = r_fail;
        n_eff      = r_eff;
        n_room     = r_room;
        n_own_lim  = r_own_lim;
        n_own_used = r_own_used;
        n_done     = 1'b0;
        n_status   = r_status;
        n_o_lim    = r_o_lim;
        n_o_used   = r_o_used;
        n_o_eff    = r_o_eff;
        n_o_room   = r_o_room;

        ram_we    = 1'b0;
        ram_waddr = to_addr(r_id);
        ram_wdata = '0;
        ram_raddr = to_addr(r_id);

        fin       = 1'b0;
        fin_st    = ST_OK;
        walk_stop = 1'b0;
        end_n     = r_cnt;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(NUM_ACCOUNTS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_req      = i_req_type;
                    n_id       = i_account_id;
                    n_pid      = i_parent_id;
                    n_hp       = i_has_parent;
                    n_amt      = i_amount;
                    n_lim      = i_limit_value;
                    n_cnt      = '0;
                    n_first    = 1'b1;
                    n_fail     = 1'b0;
                    n_eff      = '1;
                    n_room     = '1;
                    n_own_lim  = '0;
                    n_own_used = '0;
                    ram_raddr  = to_addr(i_account_id);
                    priority case (i_req_type)
                        REQ_CREATE, REQ_RESERVE, REQ_UNRESERVE,
                        REQ_SET_LIMIT, REQ_READ: begin
                            if (!in_range(i_account_id)) begin
                                fin    = 1'b1;
                                fin_st = ST_INVALID;
                            end else if (i_req_type == REQ_CREATE) begin
                                n_state = S_CREATE;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            fin    = 1'b1;
                            fin_st = ST_INVALID;
                        end
                    endcase
                end
            end

            S_CREATE: begin
                // d holds the entry being created
                if (d.valid) begin
                    fin    = 1'b1;
                    fin_st = ST_INVALID;
                end else if (!r_hp) begin
                    ram_we          = 1'b1;
                    ram_wdata.valid = 1'b1;
                    ram_wdata.limit = r_lim;
                    fin             = 1'b1;
                end else if (!in_range(r_pid)) begin
                    fin    = 1'b1;
                    fin_st = ST_INVALID;
                end else begin
                    ram_raddr = to_addr(r_pid);
                    n_state   = S_WALK;
                end
            end

            S_WALK: begin
                if (!d.valid) begin
                    if (r_first) begin
                        fin    = 1'b1;
                        fin_st = ST_INVALID;
                    end else begin
                        walk_stop = 1'b1;
                        end_n     = r_cnt;
                    end
                end else if (r_req == REQ_SET_LIMIT) begin
                    ram_we          = 1'b1;
                    ram_wdata       = d;
                    ram_wdata.limit = r_lim;
                    fin             = 1'b1;
                end else begin
                    if (r_first) begin
                        n_own_lim  = d.limit;
                        n_own_used = d.used;
                    end
                    if (d.limit < r_eff) begin
                        n_eff = d.limit;
                    end
                    if (node_room < r_room) begin
                        n_room = node_room;
                    end
                    n_fail = r_fail | node_fail;
                    if (!d.has_parent) begin
                        walk_stop = 1'b1;
                        end_n     = cnt1;
                    end else if (cnt1 >= CW'(MAX_DEPTH)) begin
                        fin    = 1'b1;
                        fin_st = ST_DEEP;
                    end else if (!in_range(d.parent)) begin
                        walk_stop = 1'b1;
                        end_n     = cnt1;
                    end else begin
                        ram_raddr = to_addr(d.parent);
                        n_cnt     = cnt1;
                        n_first   = 1'b0;
                    end
                end

                if (walk_stop) begin
                    priority case (r_req)
                        REQ_CREATE: begin
                            if (end_n >= CW'(MAX_DEPTH)) begin
                                fin    = 1'b1;
                                fin_st = ST_DEEP;
                            end else begin
                                ram_we               = 1'b1;
                                ram_wdata.valid      = 1'b1;
                                ram_wdata.has_parent = 1'b1;
                                ram_wdata.parent     = r_pid;
                                ram_wdata.limit      = r_lim;
                                fin                  = 1'b1;
                            end
                        end
                        REQ_RESERVE, REQ_UNRESERVE: begin
                            if (n_fail) begin
                                fin    = 1'b1;
                                fin_st = (r_req == REQ_RESERVE) ? ST_LIMIT : ST_UNDERFLOW;
                            end else begin
                                ram_raddr = to_addr(r_id);
                                n_state   = S_COMMIT;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_COMMIT: begin
                // second pass: chain already known good and bounded
                if (!d.valid) begin
                    fin = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = to_addr(r_id);
                    ram_wdata = d;
                    ram_wdata.used = alu_res;
                    if (!r_first) begin
                        ram_waddr = to_addr(r_pid);
                    end
                    if (!d.has_parent || !in_range(d.parent)) begin
                        fin = 1'b1;
                    end else begin
                        ram_raddr = to_addr(d.parent);
                        n_pid     = d.parent;
                        n_first   = 1'b0;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state  = S_IDLE;
            n_done   = 1'b1;
            n_status = fin_st;
            if (fin_st == ST_OK && r_req == REQ_READ && r_state == S_WALK) begin
                n_o_lim  = n_own_lim;
                n_o_used = n_own_used;
                n_o_eff  = n_eff;
                n_o_room = n_room;
            end else begin
                n_o_lim  = '0;
                n_o_used = '0;
                n_o_eff  = '0;
                n_o_room = '0;
            end
        end
    end

    // In the commit pass r_first marks the account itself; later nodes are
    // tracked through r_pid, which the commit pass loads with each parent it follows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
        r_req      <= n_req;
        r_id       <= n_id;
        r_hp       <= n_hp;
        r_amt      <= n_amt;
        r_lim      <= n_lim;
        r_cnt      <= n_cnt;
        r_fail     <= n_fail;
        r_eff      <= n_eff;
        r_room     <= n_room;
        r_own_lim  <= n_own_lim;
        r_own_used <= n_own_used;
        r_status   <= n_status;
        r_o_lim    <= n_o_lim;
        r_o_used   <= n_o_used;
        r_o_eff    <= n_o_eff;
        r_o_room   <= n_o_room;
        if (r_state == S_WALK && n_state == S_COMMIT) begin
            r_first <= 1'b1;
            r_pid   <= r_id;
        end else begin
            r_first <= n_first;
            r_pid   <= n_pid;
        end
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_done               = r_done;
    assign o_status             = r_status;
    assign o_own_limit          = r_o_lim;
    assign o_own_used           = r_o_used;
    assign o_effective_limit    = r_o_eff;
    assign o_effective_headroom = r_o_room;

endmodule

FILE: tb/hierarchical_quota_ledger_test.sv
// Self-checking testbench for hierarchical_quota_ledger: directed and random requests
// against a cycle-free ledger predictor. Depends on hql_pkg and the block's RTL only.
`timescale 1ns / 100ps

module hierarchical_quota_ledger_test;
    import hql_pkg::*;

    localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
    localparam logic [2:0] REQ_BAD_LAST  = 3'd7;
    localparam logic [VALUE_W-1:0] NO_LIMIT = '1;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [2:0]          req;
        logic [ID_W-1:0]     id;
        logic [ID_W-1:0]     pid;
        logic                linked;
        logic [AMOUNT_W-1:0] amount;
        logic [VALUE_W-1:0]  limit;
        bit                  drain;
    } t_request;

    typedef struct {
        logic [2:0]         status;
        logic [VALUE_W-1:0] own_limit;
        logic [VALUE_W-1:0] own_used;
        logic [VALUE_W-1:0] eff_limit;
        logic [VALUE_W-1:0] headroom;
    } t_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [2:0]          i_req_type = '0;
    logic [ID_W-1:0]     i_account_id = '0;
    logic [ID_W-1:0]     i_parent_id = '0;
    logic                i_has_parent = 1'b0;
    logic [AMOUNT_W-1:0] i_amount = '0;
    logic [VALUE_W-1:0]  i_limit_value = '0;
    logic                o_done;
    logic [2:0]          o_status;
    logic [VALUE_W-1:0]  o_own_limit;
    logic [VALUE_W-1:0]  o_own_used;
    logic [VALUE_W-1:0]  o_effective_limit;
    logic [VALUE_W-1:0]  o_effective_headroom;

    hierarchical_quota_ledger i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_req_type           (i_req_type),
        .i_account_id         (i_account_id),
        .i_parent_id          (i_parent_id),
        .i_has_parent         (i_has_parent),
        .i_amount             (i_amount),
        .i_limit_value        (i_limit_value),
        .o_done               (o_done),
        .o_status             (o_status),
        .o_own_limit          (o_own_limit),
        .o_own_used           (o_own_used),
        .o_effective_limit    (o_effective_limit),
        .o_effective_headroom (o_effective_headroom)
    );

    always #5 i_clk = ~i_clk;

    t_request request_backlog[$];
    t_reply   ledger_replies_due[$];
    int       fail_count = 0;

    // Predicted ledger contents.
    bit                 acct_live   [HQL_NUM_ACCOUNTS];
    bit                 acct_linked [HQL_NUM_ACCOUNTS];
    logic [ID_W-1:0]    acct_parent [HQL_NUM_ACCOUNTS];
    logic [VALUE_W-1:0] acct_limit  [HQL_NUM_ACCOUNTS];
    logic [VALUE_W-1:0] acct_used   [HQL_NUM_ACCOUNTS];
    logic [ID_W-1:0]    chain_path  [HQL_MAX_DEPTH];

    // Stimulus-side view of which accounts exist and how deep they sit.
    bit              plan_made  [HQL_NUM_ACCOUNTS];
    int              plan_depth [HQL_NUM_ACCOUNTS];
    logic [ID_W-1:0] plan_ids[$];

    // Fills chain_path with the account and its ancestors; 0 if the chain is too deep.
    function automatic int chain_walk(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] cur;
        cur = id;
        for (int n = 0; n < HQL_MAX_DEPTH; n++) begin
            chain_path[n] = cur;
            if (!acct_linked[cur]) return n + 1;
            if (n + 1 >= HQL_MAX_DEPTH) return 0;
            cur = acct_parent[cur];
            if (!acct_live[cur]) return n + 1;
        end
        return 0;
    endfunction

    function automatic t_reply ledger_apply(input t_request r);
        t_reply             rep;
        int                 n;
        logic [VALUE_W-1:0] amt;
        logic [VALUE_W-1:0] room;
        logic [VALUE_W-1:0] lim;
        logic [VALUE_W-1:0] used;
        logic [ID_W-1:0]    a;
        rep.status    = ST_OK;
        rep.own_limit = '0;
        rep.own_used  = '0;
        rep.eff_limit = '0;
        rep.headroom  = '0;
        amt = {{(VALUE_W-AMOUNT_W){1'b0}}, r.amount};

        if (r.req == REQ_CREATE) begin
            if (acct_live[r.id] || (r.linked && !acct_live[r.pid])) begin
                rep.status = ST_INVALID;
            end else begin
                if (r.linked) begin
                    n = chain_walk(r.pid);
                    if (n == 0 || n >= HQL_MAX_DEPTH) rep.status = ST_DEEP;
                end
                if (rep.status == ST_OK) begin
                    acct_live[r.id]   = 1'b1;
                    acct_linked[r.id] = r.linked;
                    acct_parent[r.id] = r.linked ? r.pid : '0;
                    acct_limit[r.id]  = r.limit;
                    acct_used[r.id]   = '0;
                end
            end
            return rep;
        end

        if (r.req > REQ_READ || !acct_live[r.id]) begin
            rep.status = ST_INVALID;
            return rep;
        end

        if (r.req == REQ_SET_LIMIT) begin
            acct_limit[r.id] = r.limit;
            return rep;
        end

        n = chain_walk(r.id);
        if (n == 0) begin
            rep.status = ST_DEEP;
            return rep;
        end

        if (r.req == REQ_RESERVE) begin
            // no wrap: compare against limit - amount only once amount fits
            for (int i = 0; i < n; i++) begin
                a = chain_path[i];
                if (rep.status == ST_OK &&
                    (amt > acct_limit[a] || acct_used[a] > acct_limit[a] - amt))
                    rep.status = ST_LIMIT;
            end
            if (rep.status == ST_OK)
                for (int i = 0; i < n; i++) acct_used[chain_path[i]] += amt;
        end else if (r.req == REQ_UNRESERVE) begin
            for (int i = 0; i < n; i++)
                if (acct_used[chain_path[i]] < amt) rep.status = ST_UNDERFLOW;
            if (rep.status == ST_OK)
                for (int i = 0; i < n; i++) acct_used[chain_path[i]] -= amt;
        end else begin
            rep.eff_limit = NO_LIMIT;
            rep.headroom  = NO_LIMIT;
            for (int i = 0; i < n; i++) begin
                a    = chain_path[i];
                lim  = acct_limit[a];
                used = acct_used[a];
                room = (lim < used) ? '0 : lim - used;
                if (lim < rep.eff_limit) rep.eff_limit = lim;
                if (room < rep.headroom) rep.headroom = room;
            end
            rep.own_limit = acct_limit[r.id];
            rep.own_used  = acct_used[r.id];
        end
        return rep;
    endfunction

    // Queues one request and tracks which creates will take hold.
    task automatic add_request(input logic [2:0] req, input logic [ID_W-1:0] id,
                               input logic [ID_W-1:0] pid, input logic linked,
                               input logic [AMOUNT_W-1:0] amount,
                               input logic [VALUE_W-1:0] limit);
        t_request r;
        r = '{req: req, id: id, pid: pid, linked: linked, amount: amount,
              limit: limit, drain: 1'b0};
        request_backlog.push_back(r);
        if (req == REQ_CREATE && !plan_made[id] && (!linked || plan_made[pid])) begin
            if (!linked || plan_depth[pid] < HQL_MAX_DEPTH) begin
                plan_made[id]  = 1'b1;
                plan_depth[id] = linked ? plan_depth[pid] + 1 : 1;
                plan_ids.push_back(id);
            end
        end
    endtask

    task automatic add_drain();
        t_request r;
        r = '{req: REQ_READ, id: '0, pid: '0, linked: 1'b0, amount: '0,
              limit: '0, drain: 1'b1};
        request_backlog.push_back(r);
    endtask

    function automatic logic [VALUE_W-1:0] rand_wide();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'($urandom());
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom());
    endfunction

    function automatic logic [VALUE_W-1:0] pick_limit();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) return NO_LIMIT;
        if (sel < 65) return VALUE_W'($urandom_range(0, 5000));
        if (sel < 80) return rand_wide();
        if (sel < 90) return '0;
        return NO_LIMIT - VALUE_W'($urandom_range(0, 1000));
    endfunction

    function automatic logic [AMOUNT_W-1:0] pick_amount();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return AMOUNT_W'($urandom_range(0, 400));
        if (sel < 75) return AMOUNT_W'($urandom_range(0, 5000));
        if (sel < 90) return $urandom();
        if (sel < 95) return '0;
        return '1;
    endfunction

    function automatic logic [ID_W-1:0] pick_target();
        if (plan_ids.size() != 0 && $urandom_range(0, 99) < 88)
            return plan_ids[$urandom_range(0, plan_ids.size() - 1)];
        return ID_W'($urandom());
    endfunction

    task automatic build_directed();
        add_request(REQ_READ, 0, rand_id(), rand_bit(), $urandom(), rand_wide());
        add_request(REQ_RESERVE, 9, rand_id(), rand_bit(), 5, rand_wide());
        add_request(REQ_BAD_FIRST, 0, rand_id(), rand_bit(), $urandom(), rand_wide());
        add_request(REQ_BAD_LAST, 0, rand_id(), rand_bit(), $urandom(), rand_wide());
        add_request(REQ_CREATE, 0, 63, 1'b0, $urandom(), NO_LIMIT);
        // already created, then unknown parent
        add_request(REQ_CREATE, 0, 0, 1'b0, $urandom(), 7);
        add_request(REQ_CREATE, 1, 50, 1'b1, $urandom(), 7);
        add_request(REQ_CREATE, 1, 0, 1'b1, $urandom(), 1000);
        for (int i = 2; i < HQL_MAX_DEPTH; i++)
            add_request(REQ_CREATE, ID_W'(i), ID_W'(i - 1), 1'b1, $urandom(), NO_LIMIT);
        // chain of account 15 is full: one more level is too deep
        add_request(REQ_CREATE, 16, 15, 1'b1, $urandom(), NO_LIMIT);
        add_request(REQ_RESERVE, 15, rand_id(), rand_bit(), 100, rand_wide());
        add_request(REQ_RESERVE, 15, rand_id(), rand_bit(), '1, rand_wide());
        add_request(REQ_UNRESERVE, 15, rand_id(), rand_bit(), 101, rand_wide());
        add_request(REQ_SET_LIMIT, 15, rand_id(), rand_bit(), $urandom(), 50);
        add_request(REQ_READ, 15, rand_id(), rand_bit(), $urandom(), rand_wide());
        // limit now below used: even a zero reserve is refused
        add_request(REQ_RESERVE, 15, rand_id(), rand_bit(), 0, rand_wide());
        add_request(REQ_UNRESERVE, 15, rand_id(), rand_bit(), 100, rand_wide());
        add_request(REQ_CREATE, 63, 63, 1'b0, $urandom(), '0);
        add_request(REQ_RESERVE, 63, rand_id(), rand_bit(), 0, rand_wide());
        add_request(REQ_READ, 63, rand_id(), rand_bit(), $urandom(), rand_wide());
        add_drain();
    endtask

    task automatic build_random(input int count);
        int              sel;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] pid;
        logic            linked;
        for (int k = 0; k < count; k++) begin
            if (k == count / 3 || k == 2 * count / 3) add_drain();
            sel = $urandom_range(0, 99);
            if (sel < ((plan_ids.size() < HQL_NUM_ACCOUNTS) ? 12 : 3)) begin
                id = ID_W'($urandom());
                for (int t = 0; t < 8 && plan_made[id]; t++) id = ID_W'($urandom());
                linked = ($urandom_range(0, 3) != 0);
                pid = pick_target();
                add_request(REQ_CREATE, id, pid, linked, $urandom(), pick_limit());
            end else if (sel < 42) begin
                add_request(REQ_RESERVE, pick_target(), rand_id(), rand_bit(),
                            pick_amount(), rand_wide());
            end else if (sel < 65) begin
                add_request(REQ_UNRESERVE, pick_target(), rand_id(), rand_bit(),
                            pick_amount(), rand_wide());
            end else if (sel < 75) begin
                add_request(REQ_SET_LIMIT, pick_target(), rand_id(), rand_bit(),
                            $urandom(), pick_limit());
            end else if (sel < 97) begin
                add_request(REQ_READ, pick_target(), rand_id(), rand_bit(),
                            $urandom(), rand_wide());
            end else begin
                add_request(3'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST)), pick_target(),
                            rand_id(), rand_bit(), $urandom(), rand_wide());
            end
        end
    endtask

    // Driver: sends words in bursts with random gaps.
    t_request active_word;
    int       burst_left = 1;
    int       gap_left = 0;

    always @(posedge i_clk) begin
        logic next_start;
        next_start = start;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else begin
            if (start && !busy) begin
                ledger_replies_due.push_back(ledger_apply(active_word));
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_backlog.size() != 0) begin
                    if (request_backlog[0].drain) begin
                        // hold off until every outstanding reply has been taken
                        if (ledger_replies_due.size() == 0 && o_done !== 1'b1)
                            void'(request_backlog.pop_front());
                    end else begin
                        active_word   = request_backlog.pop_front();
                        i_req_type    <= active_word.req;
                        i_account_id  <= active_word.id;
                        i_parent_id   <= active_word.pid;
                        i_has_parent  <= active_word.linked;
                        i_amount      <= active_word.amount;
                        i_limit_value <= active_word.limit;
                        next_start = 1'b1;
                        burst_left--;
                        if (burst_left <= 0) begin
                            if ($urandom_range(0, 7) == 0) begin
                                burst_left = 60;
                                gap_left   = 0;
                            end else begin
                                burst_left = $urandom_range(1, 12);
                                gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                         : $urandom_range(1, 25);
                            end
                        end
                    end
                end
            end
        end
        start <= next_start;
    end

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: every strobed reply is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_done === 1'b1) begin
            if (ledger_replies_due.size() == 0) begin
                $display("%0t: reply word with nothing outstanding, status %0h",
                         $time, o_status);
                fail_count++;
            end else begin
                want = ledger_replies_due.pop_front();
                check_field("status", VALUE_W'(want.status), VALUE_W'(o_status));
                check_field("own_limit", want.own_limit, o_own_limit);
                check_field("own_used", want.own_used, o_own_used);
                check_field("effective_limit", want.eff_limit, o_effective_limit);
                check_field("effective_headroom", want.headroom, o_effective_headroom);
            end
        end
    end

    initial begin
        build_directed();
        build_random(1700);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (request_backlog.size() != 0 || start || ledger_replies_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && ledger_replies_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
